// File: sv/four_phase_hex_processor_macros.svh
// Assertion macros for the four-phase hex processor.
// Used by the top level; expects signals clk and rst in scope.
`ifndef FOUR_PHASE_HEX_PROCESSOR_MACROS_SVH
`define FOUR_PHASE_HEX_PROCESSOR_MACROS_SVH

// Checked on every clock edge outside of reset
`define FPHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included
`define FPHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/fphp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the four-phase hex processor.
// No dependencies.
package fphp_pkg;

  // item action codes
  localparam logic [1:0] ACT_CLOCK = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // phase work, selected by phase-1 count modulo 4
  localparam logic [1:0] PH_FETCH = 2'd0;
  localparam logic [1:0] PH_INCPC = 2'd1;
  localparam logic [1:0] PH_EXEC  = 2'd2;

  // opcodes
  localparam logic [3:0] OP_LDAM = 4'd0;
  localparam logic [3:0] OP_LDBM = 4'd1;
  localparam logic [3:0] OP_STAM = 4'd2;
  localparam logic [3:0] OP_LDAC = 4'd3;
  localparam logic [3:0] OP_LDBC = 4'd4;
  localparam logic [3:0] OP_LDAP = 4'd5;
  localparam logic [3:0] OP_LDAI = 4'd6;
  localparam logic [3:0] OP_LDBI = 4'd7;
  localparam logic [3:0] OP_STAI = 4'd8;
  localparam logic [3:0] OP_BR   = 4'd9;
  localparam logic [3:0] OP_BRZ  = 4'd10;
  localparam logic [3:0] OP_BRN  = 4'd11;
  localparam logic [3:0] OP_BRB  = 4'd12;
  localparam logic [3:0] OP_OPR  = 4'd13;
  localparam logic [3:0] OP_PFIX = 4'd14;
  localparam logic [3:0] OP_NFIX = 4'd15;

  // OPR sub-operations
  localparam logic [15:0] OPR_ADD = 16'd0;
  localparam logic [15:0] OPR_SUB = 16'd1;

  localparam logic [15:0] NFIX_MASK = 16'hff00;

  // architectural registers
  typedef struct packed {
    logic [3:0]  cnt0;
    logic [3:0]  cnt1;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] pc;
    logic [15:0] operand;
    logic [3:0]  func;
  } arch_t;

  // one input item
  typedef struct packed {
    logic [1:0]  action;
    logic        phase0_clock;
    logic        phase0_reset;
    logic        phase1_clock;
    logic        phase1_reset;
    logic [7:0]  instr_byte;
    logic [14:0] mem_address;
    logic [15:0] mem_data;
  } item_t;

  // memory access needed by an item
  typedef struct packed {
    logic        re;
    logic        we;
    logic [14:0] addr;
  } memreq_t;

  // phase-1 latch update
  function automatic logic [3:0] next_cnt1(input logic c1, input logic r1,
                                           input logic [3:0] cnt0,
                                           input logic [3:0] cnt1);
    logic [3:0] res;
    if (c1) res = cnt0;
    else if (r1) res = 4'd0;
    else res = cnt1;
    return res;
  endfunction

endpackage

// File: sv/fphp_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fphp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: sv/fphp_issue.sv
`timescale 1ns / 1ps
// Decodes an incoming item into the memory access it needs.
// Depends on fphp_pkg.
module fphp_issue (
  input  fphp_pkg::item_t   item,
  input  fphp_pkg::arch_t   arch,
  input  logic              fetch_ram,
  output fphp_pkg::memreq_t req
);

  logic [3:0]  cnt1n;
  logic [15:0] sum_a;
  logic [15:0] sum_b;

  assign cnt1n = fphp_pkg::next_cnt1(item.phase1_clock, item.phase1_reset,
                                     arch.cnt0, arch.cnt1);
  assign sum_a = arch.a + arch.operand;
  assign sum_b = arch.b + arch.operand;

  // address and direction per action / phase / opcode
  always_comb begin
    req = '0;
    unique case (item.action)
      fphp_pkg::ACT_WRITE: begin
        req.we   = 1'b1;
        req.addr = item.mem_address;
      end
      fphp_pkg::ACT_READ: begin
        req.re   = 1'b1;
        req.addr = item.mem_address;
      end
      fphp_pkg::ACT_CLOCK: begin
        if (item.phase0_clock) begin
          if (cnt1n[1:0] == fphp_pkg::PH_FETCH) begin
            req.re   = fetch_ram;
            req.addr = arch.pc[15:1];
          end else if (cnt1n[1:0] == fphp_pkg::PH_EXEC) begin
            unique case (arch.func)
              fphp_pkg::OP_LDAM, fphp_pkg::OP_LDBM: begin
                req.re   = 1'b1;
                req.addr = arch.operand[14:0];
              end
              fphp_pkg::OP_STAM: begin
                req.we   = 1'b1;
                req.addr = arch.operand[14:0];
              end
              fphp_pkg::OP_LDAI: begin
                req.re   = 1'b1;
                req.addr = sum_a[14:0];
              end
              fphp_pkg::OP_LDBI: begin
                req.re   = 1'b1;
                req.addr = sum_b[14:0];
              end
              fphp_pkg::OP_STAI: begin
                req.we   = 1'b1;
                req.addr = sum_b[14:0];
              end
              default: req = '0;
            endcase
          end
        end
      end
      default: req = '0;
    endcase
  end

endmodule

// File: sv/fphp_exec.sv
`timescale 1ns / 1ps
// Computes the register state after an item, given the memory read data.
// Depends on fphp_pkg.
module fphp_exec (
  input  fphp_pkg::item_t item,
  input  fphp_pkg::arch_t arch,
  input  logic            fetch_ram,
  input  logic [15:0]     rdata,
  output fphp_pkg::arch_t arch_next,
  output logic [15:0]     read_data
);

  logic [3:0]  cnt1n;
  logic [7:0]  fbyte;
  logic [15:0] op;

  assign cnt1n = fphp_pkg::next_cnt1(item.phase1_clock, item.phase1_reset,
                                     arch.cnt0, arch.cnt1);
  assign op    = arch.operand;
  // fetched byte: even PC takes the low byte
  assign fbyte = !fetch_ram ? item.instr_byte :
                 (arch.pc[0] ? rdata[15:8] : rdata[7:0]);
  assign read_data = (item.action == fphp_pkg::ACT_READ) ? rdata : 16'd0;

  always_comb begin
    arch_next = arch;
    if (item.action == fphp_pkg::ACT_CLOCK) begin
      arch_next.cnt1 = cnt1n;
      if (item.phase0_clock) begin
        arch_next.cnt0 = 4'(cnt1n + 4'd1);
        unique case (cnt1n[1:0])
          fphp_pkg::PH_FETCH: begin
            arch_next.operand = {op[15:4], fbyte[3:0]};
            arch_next.func    = fbyte[7:4];
          end
          fphp_pkg::PH_INCPC: arch_next.pc = arch.pc + 16'd1;
          fphp_pkg::PH_EXEC: begin
            // every opcode but the prefixes clears the operand
            arch_next.operand = 16'd0;
            unique case (arch.func)
              fphp_pkg::OP_LDAM, fphp_pkg::OP_LDAI: arch_next.a = rdata;
              fphp_pkg::OP_LDBM, fphp_pkg::OP_LDBI: arch_next.b = rdata;
              fphp_pkg::OP_STAM, fphp_pkg::OP_STAI: arch_next.a = arch.a;
              fphp_pkg::OP_LDAC: arch_next.a = op;
              fphp_pkg::OP_LDBC: arch_next.b = op;
              fphp_pkg::OP_LDAP: arch_next.a = arch.pc + op;
              fphp_pkg::OP_BR:   arch_next.pc = arch.pc + op;
              fphp_pkg::OP_BRZ: begin
                if (arch.a == 16'd0) arch_next.pc = arch.pc + op;
              end
              fphp_pkg::OP_BRN: begin
                if (arch.a[15]) arch_next.pc = arch.pc + op;
              end
              fphp_pkg::OP_BRB:  arch_next.pc = arch.b + op;
              fphp_pkg::OP_OPR: begin
                if (op == fphp_pkg::OPR_ADD) arch_next.a = arch.a + arch.b;
                else if (op == fphp_pkg::OPR_SUB) arch_next.a = arch.a - arch.b;
              end
              fphp_pkg::OP_PFIX: arch_next.operand = {op[11:0], 4'd0};
              fphp_pkg::OP_NFIX: arch_next.operand = fphp_pkg::NFIX_MASK | {op[11:0], 4'd0};
              default: arch_next.operand = 16'd0;
            endcase
          end
          default: arch_next.cnt0 = 4'(cnt1n + 4'd1);
        endcase
      end else if (item.phase0_reset) begin
        arch_next.cnt0    = 4'd0;
        arch_next.a       = 16'd0;
        arch_next.b       = 16'd0;
        arch_next.pc      = 16'd0;
        arch_next.operand = 16'd0;
      end
    end
  end

endmodule

// File: sv/four_phase_hex_processor.sv
`timescale 1ns / 1ps
// Four-phase hex processor: 16-bit accumulator machine with its word memory.
// Depends on fphp_pkg, fphp_ram, fphp_issue, fphp_exec and the macros header.
//
// Usage:
//   Input channel (in_valid / in_stall): one item is a clock event, a memory
//   word write or a memory word read. Every item gives exactly one result on
//   the output channel (out_valid / out_stall): A, B, PC, the phase-1 count
//   and read_data (the word for a read item, zero otherwise).
//   Config channel (cfg_valid / cfg_ready, always ready): cfg_data bit 0 is
//   fetch_from_ram; write only while no item is in flight.
//   Timing: an accepted item is registered into the execute stage while its
//   memory read is issued; in the execute stage it uses the read data and
//   updates registers, memory and the output register unless the output
//   stalls. A new item is not accepted until the last one leaves execute.
//   A stalled result sits in the output register while the next item is
//   accepted and read; that item then waits in the execute stage.
//   Reset (synchronous): registers clear, fetch_from_ram returns to 1,
//   no results pending. Memory contents are left as they are.
//   MEM_WORDS must be a power of two; addresses keep their low bits.
`include "four_phase_hex_processor_macros.svh"
module four_phase_hex_processor #(
  parameter int MEM_WORDS = 32768
) (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic        phase0_clock,
  input  logic        phase0_reset,
  input  logic        phase1_clock,
  input  logic        phase1_reset,
  input  logic [7:0]  instr_byte,
  input  logic [14:0] mem_address,
  input  logic [15:0] mem_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] a_value,
  output logic [15:0] b_value,
  output logic [15:0] pc_value,
  output logic [3:0]  phase_count,
  output logic [15:0] read_data
);

  localparam int AW = $clog2(MEM_WORDS);

  fphp_pkg::arch_t   arch;
  fphp_pkg::arch_t   arch_next;
  fphp_pkg::item_t   in_item;
  fphp_pkg::item_t   s1_item;
  fphp_pkg::memreq_t req;
  logic              fetch_ram;
  logic              s1_valid;
  logic              s1_we;
  logic [AW-1:0]     s1_addr;
  logic              accept;
  logic              s1_done;
  logic              ram_re;
  logic              ram_we;
  logic [15:0]       ram_rdata;
  logic [15:0]       rd_next;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_ram <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      fetch_ram <= cfg_data;
    end
  end

  assign in_item = '{action: action, phase0_clock: phase0_clock,
                     phase0_reset: phase0_reset, phase1_clock: phase1_clock,
                     phase1_reset: phase1_reset, instr_byte: instr_byte,
                     mem_address: mem_address, mem_data: mem_data};

  // handshake: one item in execute at a time
  assign in_stall = s1_valid;
  assign accept   = in_valid && !in_stall;
  assign s1_done  = s1_valid && (!out_valid || !out_stall);

  // issue: memory request from current state
  fphp_issue u_issue (
    .item      (in_item),
    .arch      (arch),
    .fetch_ram (fetch_ram),
    .req       (req)
  );

  // memory
  assign ram_re = accept && req.re;
  assign ram_we = s1_done && s1_we;

  fphp_ram #(
    .WIDTH (16),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (s1_item.action == fphp_pkg::ACT_WRITE ? s1_item.mem_data : arch.a),
    .re    (ram_re),
    .raddr (req.addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
      s1_we   <= req.we;
      s1_addr <= req.addr[AW-1:0];
    end
  end

  fphp_exec u_exec (
    .item      (s1_item),
    .arch      (arch),
    .fetch_ram (fetch_ram),
    .rdata     (ram_rdata),
    .arch_next (arch_next),
    .read_data (rd_next)
  );

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= '0;
    end else if (s1_done) begin
      arch <= arch_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      a_value     <= arch_next.a;
      b_value     <= arch_next.b;
      pc_value    <= arch_next.pc;
      phase_count <= arch_next.cnt1;
      read_data   <= rd_next;
    end
  end

  // checks
  `FPHP_ASSERT(a_no_rw_overlap, !(ram_we && ram_re), "memory read and write in one cycle")
  `FPHP_ASSERT(a_accept_to_exec, (in_valid && !in_stall) |=> s1_valid, "accepted item lost")
  `FPHP_ASSERT(a_exec_hold, (s1_valid && !s1_done) |-> (out_valid && out_stall), "exec stalled without cause")
  `FPHP_ASSERT_ALWAYS(a_reset_empty, rst |=> (!s1_valid && !out_valid), "pipeline not empty after reset")

endmodule

// File: dv/fphp_checker.sv
`timescale 1ns / 1ps
// Result checker for the four-phase hex processor: tracks the machine state from
// accepted items and config writes, and compares every result item.
// Depends on fphp_pkg.
module fphp_checker #(
  parameter int MEM_WORDS = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic        phase0_clock,
  input  logic        phase0_reset,
  input  logic        phase1_clock,
  input  logic        phase1_reset,
  input  logic [7:0]  instr_byte,
  input  logic [14:0] mem_address,
  input  logic [15:0] mem_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] a_value,
  input  logic [15:0] b_value,
  input  logic [15:0] pc_value,
  input  logic [3:0]  phase_count,
  input  logic [15:0] read_data,
  output int          fail_count,
  output int          results_owed
);

  // visible registers after one item
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] pc;
    logic [3:0]  cnt;
    logic [15:0] rd;
  } hex_regs_t;

  // machine copy
  logic [3:0]  cnt0_m;
  logic [3:0]  cnt1_m;
  logic [15:0] a_m;
  logic [15:0] b_m;
  logic [15:0] pc_m;
  logic [15:0] opnd_m;
  logic [3:0]  func_m;
  logic        ram_fetch_m;
  logic [15:0] mem_m [MEM_WORDS];
  // words stored at least once since time zero
  bit          written_m [MEM_WORDS];

  hex_regs_t       owed_regs_q[$];
  hex_regs_t       head_regs;
  hex_regs_t       new_regs;
  fphp_pkg::item_t seen_item;

  // addresses keep their low 15 bits, then wrap at the memory size
  function automatic int unsigned word_at(input logic [15:0] addr);
    return int'(addr[14:0]) % MEM_WORDS;
  endfunction

  task automatic store_word(input int unsigned idx, input logic [15:0] val);
    mem_m[idx]     = val;
    written_m[idx] = 1'b1;
  endtask

  // memory word that an item would read in the current state, or -1
  function automatic int read_word(input fphp_pkg::item_t it);
    logic [3:0]  c1;
    logic [15:0] op;
    int          idx;
    idx = -1;
    op  = opnd_m;
    if (it.phase1_clock) c1 = cnt0_m;
    else if (it.phase1_reset) c1 = 4'd0;
    else c1 = cnt1_m;
    if (it.action == fphp_pkg::ACT_READ) begin
      idx = int'(word_at({1'b0, it.mem_address}));
    end else if (it.action == fphp_pkg::ACT_CLOCK && it.phase0_clock) begin
      if (c1[1:0] == fphp_pkg::PH_FETCH) begin
        if (ram_fetch_m) idx = int'(word_at({1'b0, pc_m[15:1]}));
      end else if (c1[1:0] == fphp_pkg::PH_EXEC) begin
        case (func_m)
          fphp_pkg::OP_LDAM, fphp_pkg::OP_LDBM: idx = int'(word_at(op));
          fphp_pkg::OP_LDAI: idx = int'(word_at(16'(a_m + op)));
          fphp_pkg::OP_LDBI: idx = int'(word_at(16'(b_m + op)));
          default: ;
        endcase
      end
    end
    return idx;
  endfunction

  // fetch phase: opcode to the function register, low nibble into the operand
  task automatic fetch_byte(input logic [7:0] ext);
    logic [15:0] w;
    logic [7:0]  fetched;
    if (ram_fetch_m) begin
      w = mem_m[word_at({1'b0, pc_m[15:1]})];
      fetched = pc_m[0] ? w[15:8] : w[7:0];
    end else begin
      fetched = ext;
    end
    opnd_m = {opnd_m[15:4], fetched[3:0]};
    func_m = fetched[7:4];
  endtask

  // execute phase
  task automatic execute_op();
    logic [15:0] op;
    op = opnd_m;
    case (func_m)
      fphp_pkg::OP_LDAM: a_m = mem_m[word_at(op)];
      fphp_pkg::OP_LDBM: b_m = mem_m[word_at(op)];
      fphp_pkg::OP_STAM: store_word(word_at(op), a_m);
      fphp_pkg::OP_LDAC: a_m = op;
      fphp_pkg::OP_LDBC: b_m = op;
      fphp_pkg::OP_LDAP: a_m = pc_m + op;
      fphp_pkg::OP_LDAI: a_m = mem_m[word_at(16'(a_m + op))];
      fphp_pkg::OP_LDBI: b_m = mem_m[word_at(16'(b_m + op))];
      fphp_pkg::OP_STAI: store_word(word_at(16'(b_m + op)), a_m);
      fphp_pkg::OP_BR:   pc_m = pc_m + op;
      fphp_pkg::OP_BRZ:  if (a_m == 16'd0) pc_m = pc_m + op;
      fphp_pkg::OP_BRN:  if (a_m[15]) pc_m = pc_m + op;
      fphp_pkg::OP_BRB:  pc_m = b_m + op;
      fphp_pkg::OP_OPR: begin
        if (op == fphp_pkg::OPR_ADD) a_m = a_m + b_m;
        else if (op == fphp_pkg::OPR_SUB) a_m = a_m - b_m;
      end
      fphp_pkg::OP_PFIX: opnd_m = {op[11:0], 4'h0};
      fphp_pkg::OP_NFIX: opnd_m = fphp_pkg::NFIX_MASK | {op[11:0], 4'h0};
    endcase
    // prefixes keep building the operand, everything else consumes it
    if (func_m != fphp_pkg::OP_PFIX && func_m != fphp_pkg::OP_NFIX) opnd_m = '0;
  endtask

  // one clock event: phase-1 latch first, then phase-0 count and phase work
  task automatic clock_event(input fphp_pkg::item_t it);
    if (it.phase1_clock) cnt1_m = cnt0_m;
    else if (it.phase1_reset) cnt1_m = '0;
    if (it.phase0_clock) begin
      cnt0_m = cnt1_m + 4'd1;
      case (cnt1_m[1:0])
        fphp_pkg::PH_FETCH: fetch_byte(it.instr_byte);
        fphp_pkg::PH_INCPC: pc_m = pc_m + 16'd1;
        fphp_pkg::PH_EXEC:  execute_op();
        default: ;
      endcase
    end else if (it.phase0_reset) begin
      cnt0_m = '0;
      a_m    = '0;
      b_m    = '0;
      pc_m   = '0;
      opnd_m = '0;
    end
  endtask

  // apply one item and capture the registers it should show
  task automatic advance_machine(input fphp_pkg::item_t it, output hex_regs_t res);
    res.rd = '0;
    case (it.action)
      fphp_pkg::ACT_CLOCK: clock_event(it);
      fphp_pkg::ACT_WRITE: store_word(word_at({1'b0, it.mem_address}), it.mem_data);
      fphp_pkg::ACT_READ:  res.rd = mem_m[word_at({1'b0, it.mem_address})];
      default: ;  // unused action: no effect
    endcase
    res.a   = a_m;
    res.b   = b_m;
    res.pc  = pc_m;
    res.cnt = cnt1_m;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cnt0_m      = '0;
      cnt1_m      = '0;
      a_m         = '0;
      b_m         = '0;
      pc_m        = '0;
      opnd_m      = '0;
      func_m      = fphp_pkg::OP_LDAM;
      ram_fetch_m = 1'b1;
      owed_regs_q.delete();
      fail_count  = 0;
    end else begin
      // result side
      if (out_valid && !out_stall) begin
        if (owed_regs_q.size() == 0) begin
          $display("%0t: result item with none outstanding, a=%h b=%h pc=%h",
                   $time, a_value, b_value, pc_value);
          fail_count++;
        end else begin
          head_regs = owed_regs_q.pop_front();
          compare_field("a_value", head_regs.a, a_value);
          compare_field("b_value", head_regs.b, b_value);
          compare_field("pc_value", head_regs.pc, pc_value);
          compare_field("phase_count", {12'd0, head_regs.cnt}, {12'd0, phase_count});
          compare_field("read_data", head_regs.rd, read_data);
        end
      end
      // config side
      if (cfg_valid && cfg_ready) ram_fetch_m = cfg_data;
      // item side
      if (in_valid && !in_stall) begin
        seen_item.action       = action;
        seen_item.phase0_clock = phase0_clock;
        seen_item.phase0_reset = phase0_reset;
        seen_item.phase1_clock = phase1_clock;
        seen_item.phase1_reset = phase1_reset;
        seen_item.instr_byte   = instr_byte;
        seen_item.mem_address  = mem_address;
        seen_item.mem_data     = mem_data;
        advance_machine(seen_item, new_regs);
        owed_regs_q.push_back(new_regs);
      end
    end
    results_owed = owed_regs_q.size();
  end

endmodule

// File: dv/tb_four_phase_hex_processor.sv
`timescale 1ns / 1ps
// Testbench top for the four-phase hex processor: clock, reset, item stimulus,
// receiver stalls and the verdict. Depends on fphp_pkg, fphp_checker and the DUT.
module tb_four_phase_hex_processor;

  localparam int          MEM_WORDS     = 32768;
  localparam int          RANDOM_PHASES = 6;
  localparam int          PHASE_ITEMS   = 120;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam logic [1:0]  ACT_UNUSED    = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic        phase0_clock;
  logic        phase0_reset;
  logic        phase1_clock;
  logic        phase1_reset;
  logic [7:0]  instr_byte;
  logic [14:0] mem_address;
  logic [15:0] mem_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] a_value;
  logic [15:0] b_value;
  logic [15:0] pc_value;
  logic [3:0]  phase_count;
  logic [15:0] read_data;

  int          fail_count;
  int          results_owed;
  int          items_sent;
  bit          sender_idles;
  int          stall_level = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  four_phase_hex_processor #(.MEM_WORDS(MEM_WORDS)) dut (.*);

  fphp_checker #(.MEM_WORDS(MEM_WORDS)) checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // timeout
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // receiver stalls: mostly short, a few long, none at level 0
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (stall_level != 0 &&
                 $urandom_range(0, 99) < (stall_level == 1 ? 10 : 35)) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 2);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_idles || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // opcode uniform, operand biased toward the OPR sub-operations
  function automatic logic [7:0] random_instr();
    logic [3:0] opc;
    logic [3:0] nib;
    opc = 4'($urandom_range(0, 15));
    nib = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
    return {opc, nib};
  endfunction

  function automatic fphp_pkg::item_t clock_item(input logic c0, input logic r0,
                                                 input logic c1, input logic r1,
                                                 input logic [7:0] ib);
    fphp_pkg::item_t it;
    it.action       = fphp_pkg::ACT_CLOCK;
    it.phase0_clock = c0;
    it.phase0_reset = r0;
    it.phase1_clock = c1;
    it.phase1_reset = r1;
    it.instr_byte   = ib;
    it.mem_address  = 15'($urandom);
    it.mem_data     = 16'($urandom);
    return it;
  endfunction

  // memory item; the clock inputs carry random junk that must be ignored
  function automatic fphp_pkg::item_t mem_item(input logic [1:0] act,
                                               input logic [14:0] addr,
                                               input logic [15:0] data);
    fphp_pkg::item_t it;
    it = clock_item(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
    it.action      = act;
    it.mem_address = addr;
    it.mem_data    = data;
    return it;
  endfunction

  // drive one item at the falling edge and hold it until accepted
  task automatic drive(input fphp_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action       = it.action;
    phase0_clock = it.phase0_clock;
    phase0_reset = it.phase0_reset;
    phase1_clock = it.phase1_clock;
    phase1_reset = it.phase1_reset;
    instr_byte   = it.instr_byte;
    mem_address  = it.mem_address;
    mem_data     = it.mem_data;
    in_valid     = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
    items_sent++;
  endtask

  // a word that was never stored is written first, so no item reads it
  task automatic send(input fphp_pkg::item_t it);
    int idx;
    idx = checker_i.read_word(it);
    if (idx >= 0) begin
      if (!checker_i.written_m[idx])
        drive(mem_item(fphp_pkg::ACT_WRITE, 15'(idx), 16'($urandom)));
    end
    drive(it);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // config write, only with the block idle
  task automatic write_fetch_mode(input logic from_ram);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_data  = from_ram;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // clear both counts and the registers
  task automatic restart_machine();
    send(clock_item(1'b0, 1'b1, 1'b0, 1'b1, 8'($urandom)));
  endtask

  // one phase: a combined event or a phase-1 / phase-0 pair
  task automatic step_phase(input logic [7:0] ib);
    if ($urandom_range(0, 1) == 1) begin
      send(clock_item(1'b1, 1'($urandom), 1'b1, 1'($urandom), ib));
    end else begin
      send(clock_item(1'b0, 1'b0, 1'b1, 1'($urandom), ib));
      send(clock_item(1'b1, 1'($urandom), 1'b0, 1'b0, ib));
    end
  endtask

  task automatic run_instr(input logic [7:0] ib);
    repeat (4) step_phase(ib);
  endtask

  // small program written at word 0, then run from PC 0
  task automatic ram_program_burst();
    int words;
    restart_machine();
    words = $urandom_range(2, 6);
    for (int i = 0; i < words; i++)
      send(mem_item(fphp_pkg::ACT_WRITE, 15'(i), {random_instr(), random_instr()}));
    repeat ($urandom_range(words, 2 * words)) run_instr(8'($urandom));
  endtask

  // instructions straight from instr_byte
  task automatic ext_burst();
    if ($urandom_range(0, 9) < 3) restart_machine();
    repeat ($urandom_range(2, 8)) run_instr(random_instr());
  endtask

  task automatic mem_burst();
    logic [14:0] addr;
    repeat ($urandom_range(1, 4)) begin
      addr = ($urandom_range(0, 1) == 1) ? 15'($urandom_range(0, 31)) : 15'($urandom);
      send(mem_item(($urandom_range(0, 1) == 1) ? fphp_pkg::ACT_WRITE : fphp_pkg::ACT_READ,
                    addr, 16'($urandom)));
    end
  endtask

  // fully random items, unused action included
  task automatic noise_burst();
    fphp_pkg::item_t it;
    repeat ($urandom_range(1, 3)) begin
      it = clock_item(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      it.action = 2'($urandom_range(0, 3));
      send(it);
    end
  endtask

  initial begin
    int              pick;
    bit              paused;
    bit              ram_mode;
    fphp_pkg::item_t it;

    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b1;
    in_valid     = 1'b0;
    action       = fphp_pkg::ACT_CLOCK;
    phase0_clock = 1'b0;
    phase0_reset = 1'b0;
    phase1_clock = 1'b0;
    phase1_reset = 1'b0;
    instr_byte   = '0;
    mem_address  = '0;
    mem_data     = '0;
    sender_idles = 1'b0;
    items_sent   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_fetch_mode(1'b1);

    stall_level = 1;

    // directed: address and data extremes
    send(mem_item(fphp_pkg::ACT_WRITE, 15'h7fff, 16'hffff));
    send(mem_item(fphp_pkg::ACT_READ, 15'h7fff, 16'h0000));
    send(mem_item(fphp_pkg::ACT_WRITE, 15'h0000,
                  {fphp_pkg::OP_LDAC, 4'h5, fphp_pkg::OP_NFIX, 4'hf}));
    send(mem_item(fphp_pkg::ACT_READ, 15'h0000, 16'hffff));
    // unused action with every other bit set
    it = clock_item(1'b1, 1'b1, 1'b1, 1'b1, 8'hff);
    it.action      = ACT_UNUSED;
    it.mem_address = 15'h7fff;
    it.mem_data    = 16'hffff;
    send(it);
    // NFIX from the low byte at even PC, LDAC from the high byte at odd PC
    restart_machine();
    repeat (8) send(clock_item(1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
    // lone phase-1 reset, lone phase-0 reset, clocks overriding resets
    send(clock_item(1'b0, 1'b0, 1'b0, 1'b1, 8'hff));
    send(clock_item(1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
    send(clock_item(1'b1, 1'b1, 1'b1, 1'b1, 8'hff));

    // random phases, alternating the fetch source
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      ram_mode = ((p % 2) == 1);
      write_fetch_mode(ram_mode);
      sender_idles = (p != 1);
      stall_level  = (p == 4) ? 0 : 1 + (p % 2);
      items_sent   = 0;
      paused       = 1'b0;
      while (items_sent < PHASE_ITEMS) begin
        // sender holds off once until everything has drained
        if (p == 2 && !paused && items_sent >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          if (ram_mode) ram_program_burst();
          else ext_burst();
        end else if (pick < 80) begin
          mem_burst();
        end else if (pick < 90) begin
          if (ram_mode) ext_burst();
          else ram_program_burst();
        end else begin
          noise_burst();
        end
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
